// ===== rtl/core/interferometric_phase_derotation_core_assert.svh =====
// Assertion macros used by the derotation core queue RTL.
`ifndef INTERFEROMETRIC_PHASE_DEROTATION_CORE_ASSERT_SVH
`define INTERFEROMETRIC_PHASE_DEROTATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ipd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared constants, codes and elaboration-time tables of the derotation core.
// ----------------------------------------------------------------------------
package ipd_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int ANGLE_STAGES = 16;
	localparam int MAX_STAGES   = 24;
	localparam int FE_WIDTH     = 16;
	localparam int PHASE_WIDTH  = 32;
	localparam int QUEUE_DEPTH  = 4;

	// Register indexes of the configuration port
	localparam logic CFG_PHASE_FORMAT = 1'b0;
	localparam logic CFG_CONJUGATE    = 1'b1;

	// Phase format codes
	typedef enum logic [1:0] {
		FMT_COMPLEX = 2'd0,
		FMT_DEGREES = 2'd1,
		FMT_RADIANS = 2'd2,
		FMT_UNUSED  = 2'd3
	} phase_format_t;

	// round(2^32 / pi)
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
	// ceil(2^39 / 45), exact floor division by 45 for 33-bit operands
	localparam logic [33:0] DEG_RECIP = 34'd12216795865;
	// Offset that makes the degree phase non-negative: 45 * 47721859
	localparam logic [32:0] DEG_OFFSET = 33'd2147483655;
	localparam logic [27:0] DEG_QOFF   = 28'd47721859;

	typedef logic [44:0][11:0] deg_tab_t;

	// Fraction of a degree step: floor((r * 4096 + 22) / 45), by the reciprocal
	function automatic deg_tab_t deg_frac_table();
		deg_tab_t t;
		for (int i = 0; i < 45; i++) begin
			t[i] = 12'(((64'(i) * 64'd4096 + 64'd22) * 64'(DEG_RECIP)) >> 39);
		end
		return t;
	endfunction

	// Arctangent of 2^-i in turn units (2^32 per turn)
	function automatic logic [31:0] atan_tab(int i);
		logic [31:0] v;
		v = 32'h0;
		unique case (i)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051E;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// Q30 inverse CORDIC gain for n stages, evaluated at elaboration
	function automatic logic [63:0] inv_gain(int n);
		logic [63:0] g;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] nu;
		logic [63:0] quo;
		logic [63:0] rm;
		g = 64'd1 << 30;
		for (int i = 0; i < n; i++) begin
			g = g + (g >> (2 * i));
		end
		v = g << 30;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int j = 0; j < 32; j++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		// long division of 2^60 + r/2 by r, one quotient bit per step
		nu  = (64'd1 << 60) + (r >> 1);
		quo = 64'd0;
		rm  = 64'd0;
		for (int j = 63; j >= 0; j--) begin
			rm = {rm[62:0], nu[j]};
			if (rm >= r) begin
				rm     = rm - r;
				quo[j] = 1'b1;
			end
		end
		return quo;
	endfunction

endpackage

// ===== rtl/core/ipd_front.sv =====
// ----------------------------------------------------------------------------
// ipd_front
// Takes pixel words and turns the flat-earth phase into a half angle.
// ----------------------------------------------------------------------------
module ipd_front #(
	parameter int SW = ipd_pkg::SAMPLE_WIDTH,
	parameter int NS = ipd_pkg::ANGLE_STAGES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          phase_format,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  fe_real,
	input  logic signed [15:0]  fe_imag,
	input  logic signed [31:0]  fe_phase,
	input  logic [4*SW-1:0]     smp_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_h,
	output logic [4*SW-1:0]     out_smp
);

	localparam int VW = 34;
	localparam ipd_pkg::deg_tab_t DEG_TAB = ipd_pkg::deg_frac_table();

	logic en;

	// stage 1
	logic                v_s1;
	logic signed [15:0]  fre_s1, fim_s1;
	logic [32:0]         u_s1;
	logic [31:0]         rad_s1;
	logic [4*SW-1:0]     smp_s1;
	logic signed [63:0]  rprod;
	logic signed [63:0]  rsum;

	// stage 2
	logic                v_s2;
	logic signed [15:0]  fre_s2, fim_s2;
	logic [32:0]         u_s2;
	logic [31:0]         rad_s2;
	logic [4*SW-1:0]     smp_s2;
	logic [49:0]         pph_s2, ppl_s2;

	// stage 3
	logic                v_s3;
	logic signed [15:0]  fre_s3, fim_s3;
	logic [32:0]         u_s3;
	logic [31:0]         rad_s3;
	logic [4*SW-1:0]     smp_s3;
	logic [27:0]         q_s3;
	logic [66:0]         qsum;

	// vectoring stages, index 0 is the fourth pipeline stage
	logic                vv_s   [NS+1];
	logic signed [VW-1:0] vx_s  [NS+1];
	logic signed [VW-1:0] vy_s  [NS+1];
	logic signed [VW-1:0] va_s  [NS+1];
	logic                vax_s  [NS+1];
	logic                vneg_s [NS+1];
	logic [31:0]         vlin_s [NS+1];
	logic [4*SW-1:0]     vsmp_s [NS+1];

	// combinational terms of the fourth stage
	logic [32:0]         rem;
	logic [5:0]          rsel;
	logic [11:0]         dfrac;
	logic [19:0]         qd;
	logic [31:0]         hdeg;
	logic [31:0]         hlin;
	logic signed [VW-1:0] re_x, im_x;
	logic signed [VW-1:0] x0, y0, a0;
	logic signed [VW-1:0] afin;
	logic signed [VW-1:0] ahalf;

	assign en       = !vv_s[NS] || out_ready;
	assign in_ready = en;

	// radian phase: half angle is p / pi in turns, rounded
	assign rprod = fe_phase * $signed({1'b0, ipd_pkg::INV_PI_Q32});
	assign rsum  = rprod + 64'sd2097152;

	// stage 1: offset degree phase, radian product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fre_s1 <= fe_real;
			fim_s1 <= fe_imag;
			u_s1   <= {fe_phase[31], fe_phase} + ipd_pkg::DEG_OFFSET;
			rad_s1 <= rsum[53:22];
			smp_s1 <= smp_in;
		end
	end

	// stage 2: partial products of the reciprocal of 45
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fre_s2 <= fre_s1;
			fim_s2 <= fim_s1;
			u_s2   <= u_s1;
			rad_s2 <= rad_s1;
			smp_s2 <= smp_s1;
			pph_s2 <= 50'(u_s1) * 50'(ipd_pkg::DEG_RECIP[33:17]);
			ppl_s2 <= 50'(u_s1) * 50'(ipd_pkg::DEG_RECIP[16:0]);
		end
	end

	// stage 3: quotient by 45
	assign qsum = {pph_s2, 17'b0} + 67'(ppl_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fre_s3 <= fre_s2;
			fim_s3 <= fim_s2;
			u_s3   <= u_s2;
			rad_s3 <= rad_s2;
			smp_s3 <= smp_s2;
			q_s3   <= qsum[66:39];
		end
	end

	// stage 4: linear half angle and vectoring start point
	always_comb begin
		rem   = u_s3 - 33'(q_s3) * 33'd45;
		rsel  = rem[5:0];
		dfrac = (rsel < 6'd45) ? DEG_TAB[rsel] : 12'd0;
		qd    = q_s3[19:0] - ipd_pkg::DEG_QOFF[19:0];
		hdeg  = {qd, 12'b0} + 32'(dfrac);
		unique case (phase_format)
			ipd_pkg::FMT_DEGREES: hlin = hdeg;
			ipd_pkg::FMT_RADIANS: hlin = rad_s3;
			default:              hlin = 32'd0;
		endcase
		re_x = VW'(fre_s3) <<< 14;
		im_x = VW'(fim_s3) <<< 14;
		if (!fre_s3[15]) begin
			x0 = re_x;
			y0 = im_x;
			a0 = '0;
		end else begin
			x0 = -re_x;
			y0 = -im_x;
			a0 = fim_s3[15] ? -(VW'(1) <<< 31) : (VW'(1) <<< 31);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv_s[0] <= 1'b0;
		end else if (en) begin
			vv_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s[0]   <= x0;
			vy_s[0]   <= y0;
			va_s[0]   <= a0;
			vax_s[0]  <= (fim_s3 == 16'sd0);
			vneg_s[0] <= fre_s3[15];
			vlin_s[0] <= hlin;
			vsmp_s[0] <= smp_s3;
		end
	end

	// vectoring CORDIC, one micro-rotation per stage
	for (genvar k = 0; k < NS; k++) begin : g_vec
		localparam logic [31:0] ATAN = ipd_pkg::atan_tab(k);
		logic signed [VW-1:0] dx, dy;
		assign dx = vx_s[k] >>> k;
		assign dy = vy_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[k+1] <= 1'b0;
			end else if (en) begin
				vv_s[k+1] <= vv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (vy_s[k] > 0) begin
					vx_s[k+1] <= vx_s[k] + dy;
					vy_s[k+1] <= vy_s[k] - dx;
					va_s[k+1] <= va_s[k] + VW'(ATAN);
				end else begin
					vx_s[k+1] <= vx_s[k] - dy;
					vy_s[k+1] <= vy_s[k] + dx;
					va_s[k+1] <= va_s[k] - VW'(ATAN);
				end
				vax_s[k+1]  <= vax_s[k];
				vneg_s[k+1] <= vneg_s[k];
				vlin_s[k+1] <= vlin_s[k];
				vsmp_s[k+1] <= vsmp_s[k];
			end
		end
	end

	// on the real axis the angle is exact; half angle rounds up
	assign afin  = vax_s[NS] ? (vneg_s[NS] ? (VW'(1) <<< 31) : '0) : va_s[NS];
	assign ahalf = (afin + VW'(1)) >>> 1;

	assign out_valid = vv_s[NS];
	assign out_h     = (phase_format == ipd_pkg::FMT_COMPLEX) ? ahalf[31:0] : vlin_s[NS];
	assign out_smp   = vsmp_s[NS];

endmodule

// ===== rtl/core/ipd_queue.sv =====
// ----------------------------------------------------------------------------
// ipd_queue
// Short word queue between the angle front end and the rotation back end.
// ----------------------------------------------------------------------------
`include "interferometric_phase_derotation_core_assert.svh"

module ipd_queue #(
	parameter int W     = 32,
	parameter int DEPTH = ipd_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign in_ready  = (cnt_q != CW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`IPD_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "queue level overflow")
	`IPD_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + CW'(1), "level not up")
	`IPD_ASSERT_NEXT(a_cnt_dn, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - CW'(1), "level not down")

endmodule

// ===== rtl/core/ipd_back.sv =====
// ----------------------------------------------------------------------------
// ipd_back
// Builds the unit rotation for a half angle and rotates master and slave.
// ----------------------------------------------------------------------------
module ipd_back #(
	parameter int SW = ipd_pkg::SAMPLE_WIDTH,
	parameter int NS = ipd_pkg::ANGLE_STAGES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            conjugate_mode,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [31:0]     in_h,
	input  logic [4*SW-1:0] in_smp,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [4*SW-1:0] out_data
);

	localparam int XW = 34;
	localparam int PW = SW + XW;
	localparam int AW = PW + 1;
	localparam logic [63:0] GAIN = ipd_pkg::inv_gain(NS);

	logic en;

	// rotation stages, index 0 holds the folded start angle
	logic                 rv_s   [NS+1];
	logic signed [XW-1:0] rx_s   [NS+1];
	logic signed [XW-1:0] ry_s   [NS+1];
	logic signed [XW-1:0] rz_s   [NS+1];
	logic                 rflip_s[NS+1];
	logic [4*SW-1:0]      rsmp_s [NS+1];

	logic                 fold;
	logic [31:0]          hfold;

	// cosine / sine stage
	logic                 v_c;
	logic signed [XW-1:0] c_c, s_c;
	logic [4*SW-1:0]      smp_c;

	// product stage
	logic                 v_p;
	logic signed [PW-1:0] p_s [8];

	logic signed [SW-1:0] mr, mi, sr, si;
	logic signed [AW-1:0] acc [4];
	logic [4*SW-1:0]      res;
	logic [4*SW-1:0]      data_q;
	logic                 valid_q;

	assign en       = !valid_q || out_ready;
	assign in_ready = en;

	// second and third quarter turn fold onto the first and fourth
	assign fold  = in_h[31] ^ in_h[30];
	assign hfold = fold ? (in_h ^ 32'h80000000) : in_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s[0] <= 1'b0;
		end else if (en) begin
			rv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]    <= XW'(GAIN);
			ry_s[0]    <= '0;
			rz_s[0]    <= XW'($signed(hfold));
			rflip_s[0] <= fold;
			rsmp_s[0]  <= in_smp;
		end
	end

	// rotation CORDIC, one micro-rotation per stage
	for (genvar k = 0; k < NS; k++) begin : g_rot
		localparam logic [31:0] ATAN = ipd_pkg::atan_tab(k);
		logic signed [XW-1:0] dx, dy;
		assign dx = rx_s[k] >>> k;
		assign dy = ry_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[k+1] <= 1'b0;
			end else if (en) begin
				rv_s[k+1] <= rv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!rz_s[k][XW-1]) begin
					rx_s[k+1] <= rx_s[k] - dy;
					ry_s[k+1] <= ry_s[k] + dx;
					rz_s[k+1] <= rz_s[k] - XW'(ATAN);
				end else begin
					rx_s[k+1] <= rx_s[k] + dy;
					ry_s[k+1] <= ry_s[k] - dx;
					rz_s[k+1] <= rz_s[k] + XW'(ATAN);
				end
				rflip_s[k+1] <= rflip_s[k];
				rsmp_s[k+1]  <= rsmp_s[k];
			end
		end
	end

	// cosine and sine with fold and conjugate applied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c <= 1'b0;
		end else if (en) begin
			v_c <= rv_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_c   <= rflip_s[NS] ? -rx_s[NS] : rx_s[NS];
			s_c   <= (rflip_s[NS] ^ conjugate_mode) ? -ry_s[NS] : ry_s[NS];
			smp_c <= rsmp_s[NS];
		end
	end

	// products
	assign mr = smp_c[SW-1:0];
	assign mi = smp_c[2*SW-1:SW];
	assign sr = smp_c[3*SW-1:2*SW];
	assign si = smp_c[4*SW-1:3*SW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= v_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0] <= mr * c_c;
			p_s[1] <= mi * s_c;
			p_s[2] <= mr * s_c;
			p_s[3] <= mi * c_c;
			p_s[4] <= sr * c_c;
			p_s[5] <= si * s_c;
			p_s[6] <= si * c_c;
			p_s[7] <= sr * s_c;
		end
	end

	// sums, rounding and saturation
	always_comb begin
		logic signed [AW-1:0] r;
		acc[0] = AW'(p_s[0]) - AW'(p_s[1]);
		acc[1] = AW'(p_s[2]) + AW'(p_s[3]);
		acc[2] = AW'(p_s[4]) + AW'(p_s[5]);
		acc[3] = AW'(p_s[6]) - AW'(p_s[7]);
		res = '0;
		for (int j = 0; j < 4; j++) begin
			r = (acc[j] + (AW'(1) <<< 29)) >>> 30;
			if (r > AW'((64'sd1 <<< (SW - 1)) - 1)) begin
				res[j*SW +: SW] = {1'b0, {(SW-1){1'b1}}};
			end else if (r < -AW'(64'sd1 <<< (SW - 1))) begin
				res[j*SW +: SW] = {1'b1, {(SW-1){1'b0}}};
			end else begin
				res[j*SW +: SW] = r[SW-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== rtl/core/interferometric_phase_derotation_core.sv =====
// ----------------------------------------------------------------------------
// interferometric_phase_derotation_core
// Flat-earth phase removal by complex rotation of master and slave pixels.
// ----------------------------------------------------------------------------
// The core takes one pixel word per clock while s_tready is high and returns one
// word per pixel in order. The angle front end (reciprocal divide by 45 and a
// vectoring CORDIC) feeds a registered queue, which feeds the rotation back end
// (rotation CORDIC, cosine and sine, products, rounding). Throughput is one pixel
// per cycle while the output is not stalled, set by the fully pipelined CORDIC
// stages; a four-word queue lets the output side stall without stopping the
// front end at once. Configuration writes are taken at any time with cfg_ready
// high and must only occur while the core is idle.
// ----------------------------------------------------------------------------
module interferometric_phase_derotation_core #(
	parameter int SAMPLE_WIDTH = ipd_pkg::SAMPLE_WIDTH,
	parameter int ANGLE_STAGES = ipd_pkg::ANGLE_STAGES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration writes
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [1:0]                cfg_data,
	// fe_real, fe_imag, fe_phase, master_real, master_imag, slave_real, slave_imag
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [64+4*SAMPLE_WIDTH-1:0] s_tdata,
	// master_out_real, master_out_imag, slave_out_real, slave_out_imag
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [4*SAMPLE_WIDTH-1:0] m_tdata
);

	localparam int QW = 32 + 4 * SAMPLE_WIDTH;

	logic [1:0]  fmt_q;
	logic        conj_q;

	logic        f_valid, f_ready;
	logic [31:0] f_h;
	logic [4*SAMPLE_WIDTH-1:0] f_smp;
	logic        b_valid, b_ready;
	logic [QW-1:0] b_data;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= ipd_pkg::FMT_COMPLEX;
			conj_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ipd_pkg::CFG_PHASE_FORMAT: fmt_q  <= cfg_data;
				ipd_pkg::CFG_CONJUGATE:    conj_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ipd_front #(
		.SW(SAMPLE_WIDTH),
		.NS(ANGLE_STAGES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.phase_format (fmt_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.fe_real      (s_tdata[15:0]),
		.fe_imag      (s_tdata[31:16]),
		.fe_phase     (s_tdata[63:32]),
		.smp_in       (s_tdata[64 +: 4*SAMPLE_WIDTH]),
		.out_valid    (f_valid),
		.out_ready    (f_ready),
		.out_h        (f_h),
		.out_smp      (f_smp)
	);

	ipd_queue #(
		.W(QW),
		.DEPTH(ipd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_smp, f_h}),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	ipd_back #(
		.SW(SAMPLE_WIDTH),
		.NS(ANGLE_STAGES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.conjugate_mode (conj_q),
		.in_valid       (b_valid),
		.in_ready       (b_ready),
		.in_h           (b_data[31:0]),
		.in_smp         (b_data[QW-1:32]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_data       (m_tdata)
	);

endmodule
